>>> rtl/bssc_pkg.sv
// ----------------------------------------------------------------------------
// bssc_pkg
// shared types, constants and modular arithmetic for the step sequence counter
// ----------------------------------------------------------------------------
package bssc_pkg;

    localparam int CNT_W = 30;

    localparam logic [CNT_W-1:0] COUNT_MOD = 30'd1000000007;
    localparam logic [31:0]      MOD_X1    = 32'd1000000007;
    localparam logic [31:0]      MOD_X2    = 32'd2000000014;

    localparam logic [7:0] MAX_VALUE_RST = 8'd100;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the accepted item, restart the sweep
        logic run;    // sweep in progress
        logic first;  // item seeds a new sequence
        logic emit;   // move the total into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic sweep_done;
        logic last;
        logic out_busy;
    } t_dp_sts;

    // (a + b + c) mod p for operands already below p
    function automatic logic [CNT_W-1:0] mod_sum3(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b,
                                                  input logic [CNT_W-1:0] c);
        logic [31:0] s;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c};
        if (s >= MOD_X2) begin
            s = s - MOD_X2;
        end else if (s >= MOD_X1) begin
            s = s - MOD_X1;
        end
        return s[CNT_W-1:0];
    endfunction

    // (a + b) mod p for operands already below p
    function automatic logic [CNT_W-1:0] mod_add2(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, COUNT_MOD}) begin
            s = s - {1'b0, COUNT_MOD};
        end
        return s[CNT_W-1:0];
    endfunction

endpackage

>>> rtl/bssc_ram.sv
// ----------------------------------------------------------------------------
// bssc_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bssc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bssc_datapath.sv
// ----------------------------------------------------------------------------
// bssc_datapath
// count memory sweep with three-entry window, running total, output register
// ----------------------------------------------------------------------------
module bssc_datapath #(
    parameter int VALUE_SLOTS = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic [7:0]          i_s_tdata,
    input  logic                i_s_tlast,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic [31:0]         o_m_tdata,
    input  bssc_pkg::t_dp_cmd   i_cmd,
    output bssc_pkg::t_dp_sts   o_sts
);

    localparam int AW = $clog2(VALUE_SLOTS);
    localparam int CW = $clog2(VALUE_SLOTS + 3);
    localparam int XW = (CW > 9) ? CW : 9;
    localparam logic [CW-1:0] SLOTS_C  = CW'(VALUE_SLOTS);
    localparam logic [CW-1:0] DONE_CNT = CW'(VALUE_SLOTS + 2);

    logic [7:0]                 r_max_value;
    logic [7:0]                 r_fixed;
    logic                       r_last;
    logic [CW-1:0]              r_cnt;
    logic [bssc_pkg::CNT_W-1:0] r_prev;
    logic [bssc_pkg::CNT_W-1:0] r_cur;
    logic                       r_wen;
    logic [AW-1:0]              r_waddr;
    logic [bssc_pkg::CNT_W-1:0] r_wdata;
    logic [bssc_pkg::CNT_W-1:0] r_acc;
    logic                       r_out_valid;
    logic [bssc_pkg::CNT_W-1:0] r_out_data;

    logic                       rd_en;
    logic [bssc_pkg::CNT_W-1:0] rd_data;
    logic [XW-1:0]              cnt_x;
    logic [XW-1:0]              max_x;
    logic [XW-1:0]              fix_x;
    logic [CW-1:0]              v_idx;
    logic                       in_sweep;
    logic                       next_ok;
    logic                       keep;
    logic [bssc_pkg::CNT_W-1:0] next_val;
    logic [bssc_pkg::CNT_W-1:0] sum_val;
    logic [bssc_pkg::CNT_W-1:0] n_wdata;

    // at sweep count i, slot i is read and slot i-2 is computed
    always_comb begin
        rd_en    = i_cmd.run && (r_cnt < SLOTS_C);
        cnt_x    = XW'(r_cnt);
        max_x    = XW'(r_max_value);
        fix_x    = XW'(r_fixed);
        v_idx    = r_cnt - CW'(2);
        in_sweep = i_cmd.run && (r_cnt >= CW'(2)) && (r_cnt <= SLOTS_C + CW'(1));
        // upper neighbor exists only below the active limit
        next_ok  = (cnt_x <= max_x) && (r_cnt <= SLOTS_C);
        next_val = next_ok ? rd_data : '0;
        // slot lies below the limit and matches the fixed value if any
        keep     = (cnt_x <= max_x + XW'(1)) &&
                   ((r_fixed == 8'd0) || (cnt_x == fix_x + XW'(1)));
        sum_val  = bssc_pkg::mod_sum3(r_prev, r_cur, next_val);
        if (!keep) begin
            n_wdata = '0;
        end else if (i_cmd.first) begin
            n_wdata = bssc_pkg::CNT_W'(1);
        end else begin
            n_wdata = sum_val;
        end
    end

    bssc_ram #(
        .WIDTH (bssc_pkg::CNT_W),
        .DEPTH (VALUE_SLOTS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (r_wen),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_re    (rd_en),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= bssc_pkg::MAX_VALUE_RST;
            r_cnt       <= '0;
            r_wen       <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_value <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_cnt <= '0;
                r_acc <= '0;
            end else if (i_cmd.run) begin
                r_cnt <= r_cnt + CW'(1);
            end
            r_wen <= in_sweep;
            if (r_wen) begin
                r_acc <= bssc_pkg::mod_add2(r_acc, r_wdata);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fixed <= i_s_tdata;
            r_last  <= i_s_tlast;
        end
        if (i_cmd.run) begin
            if (r_cnt == '0) begin
                r_cur <= '0;
            end else begin
                r_prev <= r_cur;
                r_cur  <= rd_data;
            end
        end
        r_waddr <= v_idx[AW-1:0];
        r_wdata <= n_wdata;
        if (i_cmd.emit) begin
            r_out_data <= r_acc;
        end
    end

    assign o_m_tvalid       = r_out_valid;
    assign o_m_tdata        = {2'b00, r_out_data};
    assign o_sts.sweep_done = i_cmd.run && (r_cnt == DONE_CNT);
    assign o_sts.last       = r_last;
    assign o_sts.out_busy   = r_out_valid && !i_m_tready;

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wen && rd_en) |-> (r_waddr != r_cnt[AW-1:0]))
        else $error("count write hits the slot being read");

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc < bssc_pkg::COUNT_MOD)
        else $error("running total not reduced");

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == DONE_CNT) |-> i_cmd.run)
        else $error("sweep counter at end outside a sweep");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid && (r_out_data == $past(r_acc)))
        else $error("total not loaded into output register");

endmodule

>>> rtl/bssc_ctrl.sv
// ----------------------------------------------------------------------------
// bssc_ctrl
// item sequencer: accept, sweep, hand over the total
// ----------------------------------------------------------------------------
module bssc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output bssc_pkg::t_dp_cmd o_cmd,
    input  bssc_pkg::t_dp_sts i_sts
);

    bssc_pkg::t_state r_state;
    bssc_pkg::t_state n_state;
    logic             r_first;
    logic             n_first;

    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        o_cmd.load  = 1'b0;
        o_cmd.run   = 1'b0;
        o_cmd.first = r_first;
        o_cmd.emit  = 1'b0;
        o_s_tready  = 1'b0;
        case (r_state)
            bssc_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bssc_pkg::ST_RUN;
                end
            end
            bssc_pkg::ST_RUN: begin
                o_cmd.run = 1'b1;
                if (i_sts.sweep_done) begin
                    if (i_sts.last) begin
                        n_state = bssc_pkg::ST_HOLD;
                    end else begin
                        n_first = 1'b0;
                        n_state = bssc_pkg::ST_IDLE;
                    end
                end
            end
            bssc_pkg::ST_HOLD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_first    = 1'b1;
                    n_state    = bssc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bssc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bssc_pkg::ST_IDLE;
            r_first <= 1'b1;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_emit_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.out_busy)
        else $error("total emitted over a waiting result");

    a_first_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_first && o_s_tready)
        else $error("sequence not rearmed after result");

endmodule

>>> rtl/bounded_step_sequence_counter.sv
// ----------------------------------------------------------------------------
// bounded_step_sequence_counter
// counts bounded-step sequences with fixed positions, modulo 1000000007
// ----------------------------------------------------------------------------
// sweep: each accepted item walks the count memory through the single read port,
//   one slot a cycle; a new item is accepted only once the previous sweep is done,
//   and a last item also waits in hold until the output register is free
// result: o_m_tvalid rises once a last item's sweep is done and its total is emitted
// reset: synchronous active low; max_value returns to 100, next item seeds
//   the counts, count memory is not cleared (the seeding sweep writes all slots)
// ----------------------------------------------------------------------------
module bounded_step_sequence_counter #(
    parameter int VALUE_SLOTS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: max_value
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] position_value
    input  logic        i_s_tlast,   // last_position
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [29:0] sequence_count, [31:30] zero
);

    // command and status between sequencer and datapath
    bssc_pkg::t_dp_cmd cmd;
    bssc_pkg::t_dp_sts sts;

    // sequencer: idle -> sweep -> (hold for output slot on a last item) -> idle
    bssc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // datapath: count memory, neighbor window, modular adders, output register
    // the output register lets a new item start while a result waits
    bssc_datapath #(
        .VALUE_SLOTS (VALUE_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
